// ----- sv/tsol_pkg.sv -----
// ---------------------------------------------------------------------------
// tsol_pkg
// shared types and constants of the three-axis second-order low-pass core
// ---------------------------------------------------------------------------
`default_nettype none

package tsol_pkg;

  // sizes of the data path
  localparam int SAMPLE_WIDTH = 16;
  localparam int AXES         = 3;
  localparam int MAX_AXES     = 3;
  localparam int HIST_FRAC    = 8;
  localparam int COEF_W       = 17;
  localparam int COEF_FRAC    = 16;
  localparam int CFG_IDX_W    = 8;

  // coefficient reset values, 16 fraction bits
  localparam logic [COEF_W-1:0] INPUT_GAIN_RST      = COEF_W'(65536);
  localparam logic [COEF_W-1:0] FIRST_FEEDBACK_RST  = '0;
  localparam logic [COEF_W-1:0] SECOND_FEEDBACK_RST = '0;

  // register indexes of the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_GAIN      = CFG_IDX_W'(0),
    REG_FIRST_FEEDBACK  = CFG_IDX_W'(1),
    REG_SECOND_FEEDBACK = CFG_IDX_W'(2)
  } cfg_reg_t;

  // filter coefficients as held in the register bank
  typedef struct packed {
    logic [COEF_W-1:0] b0;
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
  } coef_t;

  // control from the top level to every lane
  typedef struct packed {
    logic              load;
    logic              advance;
    logic              a2_wr;
    logic [COEF_W-1:0] a2_new;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ----- sv/tsol_sample_if.sv -----
// ---------------------------------------------------------------------------
// tsol_sample_if
// valid/ready channel carrying one three-axis sample per beat
// ---------------------------------------------------------------------------
`default_nettype none

interface tsol_sample_if #(
  parameter int W = tsol_pkg::SAMPLE_WIDTH
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_x;
  logic signed [W-1:0] sample_y;
  logic signed [W-1:0] sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/tsol_filtered_if.sv -----
// ---------------------------------------------------------------------------
// tsol_filtered_if
// valid/ready channel carrying one three-axis filtered result per beat
// ---------------------------------------------------------------------------
`default_nettype none

interface tsol_filtered_if #(
  parameter int W = tsol_pkg::SAMPLE_WIDTH
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] filtered_x;
  logic signed [W-1:0] filtered_y;
  logic signed [W-1:0] filtered_z;

  modport source (output valid, output filtered_x, output filtered_y, output filtered_z,
                  input ready);
  modport sink   (input valid, input filtered_x, input filtered_y, input filtered_z,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/tsol_cfg_if.sv -----
// ---------------------------------------------------------------------------
// tsol_cfg_if
// register write channel: index and data, one write per beat
// ---------------------------------------------------------------------------
`default_nettype none

interface tsol_cfg_if ();
  logic                             valid;
  logic                             ready;
  logic [tsol_pkg::CFG_IDX_W-1:0]   index;
  logic [tsol_pkg::COEF_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/tsol_lane.sv -----
// ---------------------------------------------------------------------------
// tsol_lane
// one axis of the filter: gain product, history and the recurrence
// ---------------------------------------------------------------------------
`default_nettype none

module tsol_lane #(
  parameter int SW = tsol_pkg::SAMPLE_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tsol_pkg::lane_ctl_t ctl,
  input  wire tsol_pkg::coef_t     coef,
  input  wire logic signed [SW-1:0] sample,
  output logic signed [SW-1:0]     result
);
  import tsol_pkg::*;

  localparam int HW  = SW + HIST_FRAC;       // history width
  localparam int PXW = SW + COEF_W + 1;      // gain product
  localparam int PW  = HW + COEF_W + 1;      // feedback products
  localparam int AW  = HW + COEF_W + 3;      // sum of three terms
  localparam int SHW = AW - COEF_FRAC;       // sum after rounding shift

  logic signed [PXW-1:0] px;
  logic signed [HW-1:0]  last_output;
  logic signed [HW-1:0]  output_before_last;
  logic signed [PW-1:0]  p2;

  logic signed [PW-1:0]  p1;
  logic signed [HW-1:0]  p2_y;
  logic [COEF_W-1:0]     p2_c;
  logic signed [PW-1:0]  p2_next;
  logic signed [AW-1:0]  acc;
  logic signed [AW-1:0]  rsum;
  logic [SHW-1:0]        sh;
  logic                  h_ovf;
  logic [HW-1:0]         h;
  logic [HW:0]           hs;
  logic [SW:0]           q;
  logic                  r_ovf;

  // stage one: gain on the new sample, registered
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      px <= sample * $signed({1'b0, coef.b0});
    end
  end

  // feedback product of the output before last, kept one sample ahead
  always_comb begin
    p2_y    = ctl.advance ? last_output : output_before_last;
    p2_c    = ctl.advance ? coef.a2 : ctl.a2_new;
    p2_next = p2_y * $signed({1'b0, p2_c});
  end

  // recurrence: b0*x + a1*y1 - a2*y2, round and saturate to history width
  always_comb begin
    p1    = last_output * $signed({1'b0, coef.a1});
    acc   = (AW'(px) <<< HIST_FRAC) + AW'(p1) - AW'(p2);
    rsum  = acc + (AW'(1) <<< (COEF_FRAC - 1));
    sh    = rsum[AW-1:COEF_FRAC];
    h_ovf = (sh[SHW-1:HW-1] != '0) && (sh[SHW-1:HW-1] != '1);
    h     = h_ovf ? {sh[SHW-1], {(HW-1){~sh[SHW-1]}}} : sh[HW-1:0];
  end

  // result: history rounded to an integer and saturated to sample width
  always_comb begin
    hs     = {h[HW-1], h} + (HW+1)'(1 <<< (HIST_FRAC - 1));
    q      = hs[HW:HIST_FRAC];
    r_ovf  = q[SW] != q[SW-1];
    result = r_ovf ? {q[SW], {(SW-1){~q[SW]}}} : q[SW-1:0];
  end

  // history shift and feedback product update
  always_ff @(posedge clk) begin
    if (rst) begin
      last_output        <= '0;
      output_before_last <= '0;
      p2                 <= '0;
    end else begin
      if (ctl.advance) begin
        output_before_last <= last_output;
        last_output        <= h;
      end
      if (ctl.advance || ctl.a2_wr) begin
        p2 <= p2_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/tsol_merge.sv -----
// ---------------------------------------------------------------------------
// tsol_merge
// gathers the lane results into one output beat and holds it under stall
// ---------------------------------------------------------------------------
`default_nettype none

module tsol_merge #(
  parameter int SW   = tsol_pkg::SAMPLE_WIDTH,
  parameter int AXES = tsol_pkg::AXES
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 advance,
  input  wire logic [tsol_pkg::MAX_AXES-1:0][SW-1:0] lane_result,
  tsol_filtered_if.source                           filtered,
  output logic                                      busy
);
  import tsol_pkg::*;

  logic                           out_valid;
  logic [MAX_AXES-1:0][SW-1:0]    out_data;

  // output valid: set on a new beat, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (filtered.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload, one slot per lane, unused slots read as zero
  for (genvar a = 0; a < MAX_AXES; a++) begin : g_slot
    if (a < AXES) begin : g_used
      always_ff @(posedge clk) begin
        if (advance) begin
          out_data[a] <= lane_result[a];
        end
      end
    end else begin : g_unused
      assign out_data[a] = '0;
    end
  end

  assign filtered.valid      = out_valid;
  assign filtered.filtered_x = out_data[0];
  assign filtered.filtered_y = out_data[1];
  assign filtered.filtered_z = out_data[2];
  assign busy                = out_valid;

endmodule

`default_nettype wire

// ----- sv/three_axis_second_order_lowpass_core.sv -----
// ---------------------------------------------------------------------------
// three_axis_second_order_lowpass_core
// second-order IIR low-pass on three independent sensor axes
// ---------------------------------------------------------------------------
// Usage:
//   samples  : sink of x/y/z samples, one beat per sample set
//   filtered : source of rounded, saturated x/y/z results, one per sample
//   cfg      : register writes, always ready; index 0 input gain (b0),
//              1 first feedback (a1), 2 second feedback (a2); other
//              indexes are ignored. Write only while the core is empty.
// A sample beat loads the gain stage, which registers b0*x; the output register
// then loads the closed per-axis recurrence. Throughput is one sample per cycle
// unless a stalled result holds it; the history loop is a single 24x17 multiply
// plus add and saturation, and a2*y2 is formed a sample early.
// A result held by a stalled receiver does not block the pipeline until the
// gain stage is also full; then samples.ready drops until the result is taken.
// Reset (synchronous) empties the pipeline, clears the history of every axis
// and loads b0 = 1.0, a1 = a2 = 0.
// ---------------------------------------------------------------------------
`default_nettype none

module three_axis_second_order_lowpass_core #(
  parameter int SAMPLE_WIDTH = tsol_pkg::SAMPLE_WIDTH,
  parameter int AXES         = tsol_pkg::AXES
) (
  input  wire logic       clk,
  input  wire logic       rst,
  tsol_sample_if.sink     samples,
  tsol_filtered_if.source filtered,
  tsol_cfg_if.sink        cfg
);
  import tsol_pkg::*;

  coef_t                                coef;
  lane_ctl_t                            ctl;
  logic                                 gain_valid;
  logic                                 load;
  logic                                 advance;
  logic                                 busy;
  logic                                 cfg_wr;
  logic [MAX_AXES-1:0][SAMPLE_WIDTH-1:0] samp;
  logic [MAX_AXES-1:0][SAMPLE_WIDTH-1:0] lane_result;

  // coefficient register bank
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0 <= INPUT_GAIN_RST;
      coef.a1 <= FIRST_FEEDBACK_RST;
      coef.a2 <= SECOND_FEEDBACK_RST;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_INPUT_GAIN:      coef.b0 <= cfg.data;
        REG_FIRST_FEEDBACK:  coef.a1 <= cfg.data;
        REG_SECOND_FEEDBACK: coef.a2 <= cfg.data;
        default: ;
      endcase
    end
  end

  // pipeline handshake: gain stage feeds the output register
  assign advance       = gain_valid && (!busy || filtered.ready);
  assign samples.ready = !gain_valid || advance;
  assign load          = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_valid <= 1'b0;
    end else if (load) begin
      gain_valid <= 1'b1;
    end else if (advance) begin
      gain_valid <= 1'b0;
    end
  end

  // lane control
  always_comb begin
    ctl.load    = load;
    ctl.advance = advance;
    ctl.a2_wr   = cfg_wr && (cfg_reg_t'(cfg.index) == REG_SECOND_FEEDBACK);
    ctl.a2_new  = cfg.data;
  end

  assign samp[0] = samples.sample_x;
  assign samp[1] = samples.sample_y;
  assign samp[2] = samples.sample_z;

  // one lane per axis
  for (genvar a = 0; a < MAX_AXES; a++) begin : g_lane
    if (a < AXES) begin : g_used
      tsol_lane #(
        .SW (SAMPLE_WIDTH)
      ) u_lane (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .coef   (coef),
        .sample (samp[a]),
        .result (lane_result[a])
      );
    end else begin : g_unused
      assign lane_result[a] = '0;
    end
  end

  // output register
  tsol_merge #(
    .SW   (SAMPLE_WIDTH),
    .AXES (AXES)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .lane_result (lane_result),
    .filtered    (filtered),
    .busy        (busy)
  );

endmodule

`default_nettype wire

// ----- sv/tsol_check.sv -----
// ---------------------------------------------------------------------------
// tsol_check
// port-level checks of the low-pass core, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

module tsol_check #(
  parameter int W = tsol_pkg::SAMPLE_WIDTH
) (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         in_valid,
  input wire logic         in_ready,
  input wire logic         out_valid,
  input wire logic         out_ready,
  input wire logic [W-1:0] out_x,
  input wire logic [W-1:0] out_y,
  input wire logic [W-1:0] out_z
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a sample beat whose gain stage finds the output register empty yields a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 !out_valid |=> out_valid)
    else $error("result missing after sample beat");

  // a stalled result beat stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped under stall");

  // a stalled result beat keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z))
    else $error("result payload changed under stall");

endmodule

bind three_axis_second_order_lowpass_core tsol_check #(
  .W (SAMPLE_WIDTH)
) u_tsol_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (filtered.valid),
  .out_ready (filtered.ready),
  .out_x     (filtered.filtered_x),
  .out_y     (filtered.filtered_y),
  .out_z     (filtered.filtered_z)
);

`default_nettype wire
